/* hdl/sfir_pkg.sv */
// shared types and constants of the symmetric Q1.15 FIR filter
`default_nettype none

package sfir_pkg;

	localparam int TAPS_DEFAULT = 16;
	localparam int SAMPLE_W = 16;
	localparam int COEF_W = 16;
	localparam int PROD_W = 32;
	localparam int PAIRS = 8;
	localparam int PAIR_IDX_W = 3;
	localparam int FRAC_BITS = 15;
	localparam int Q15_BIAS = 32767;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [PAIR_IDX_W-1:0] pair_idx_t;

	// per-cell strobes: shift the sample row, load the product register
	typedef struct packed {
		logic shift;
		logic mul;
	} cell_ctrl_t;

	localparam coef_t PAIR_RESET [PAIRS] = '{
		16'sd10, -16'sd524, -16'sd898, -16'sd715,
		16'sd667, 16'sd3260, 16'sd6219, 16'sd8203
	};

endpackage

`default_nettype wire

/* hdl/sfir_if.sv */
// stream interfaces for the sample input and the filtered output
`default_nettype none

interface sfir_in_if;
	logic valid;
	logic ready;
	sfir_pkg::sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface sfir_out_if;
	logic valid;
	logic ready;
	sfir_pkg::sample_t sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

/* hdl/sfir_tap_cell.sv */
// one tap of the sample row: holds a sample, passes it on, registers its product
`default_nettype none

module sfir_tap_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sfir_pkg::cell_ctrl_t ctrl,
	input  wire sfir_pkg::sample_t  sample_prev,
	input  wire sfir_pkg::coef_t    coef,
	output sfir_pkg::sample_t       sample_q,
	output sfir_pkg::prod_t         prod_s2
);

	// history sample, cleared at reset so start-up taps count as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (ctrl.shift) begin
			sample_q <= sample_prev;
		end
	end

	// signed 16x16 product of this tap
	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_s2 <= sfir_pkg::PROD_W'(sample_q) * sfir_pkg::PROD_W'(coef);
		end
	end

endmodule

`default_nettype wire

/* hdl/sfir_add_tree.sv */
// registered binary adder tree over the tap products, one level per stage
`default_nettype none

module sfir_add_tree #(
	parameter int TAPS = sfir_pkg::TAPS_DEFAULT,
	parameter int AW = sfir_pkg::PROD_W + $clog2(sfir_pkg::TAPS_DEFAULT)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sfir_pkg::prod_t      leaves [TAPS],
	input  wire logic                 leaf_valid,
	output logic                      leaf_take,
	input  wire logic                 take,
	output logic signed [AW-1:0]      root,
	output logic                      root_valid
);

	localparam int LEVELS = $clog2(TAPS);
	localparam int NPAD = 1 << LEVELS;

	// heap layout: internal nodes first, then the padded leaves
	logic signed [AW-1:0] node_q [NPAD-1];
	logic signed [AW-1:0] all_val [2*NPAD-1];
	logic [LEVELS-1:0] vld_q;
	logic [LEVELS-1:0] en;
	logic [LEVELS:0] vld_chain;

	genvar gi;

	// leaves, zero beyond the last tap
	for (gi = 0; gi < NPAD; gi++) begin : g_leaf
		if (gi < TAPS) begin : g_used
			assign all_val[NPAD-1+gi] = AW'(leaves[gi]);
		end else begin : g_pad
			assign all_val[NPAD-1+gi] = '0;
		end
	end

	for (gi = 0; gi < NPAD-1; gi++) begin : g_node
		localparam int D = $clog2(gi + 2) - 1;

		assign all_val[gi] = node_q[gi];

		// sum of the two children at this depth
		always_ff @(posedge clk) begin
			if (en[D]) begin
				node_q[gi] <= all_val[2*gi+1] + all_val[2*gi+2];
			end
		end
	end

	// level enables, root side first: a level moves when empty or when drained
	always_comb begin
		en[0] = !vld_q[0] || take;
		for (int d = 1; d < LEVELS; d++) begin
			en[d] = !vld_q[d] || en[d-1];
		end
	end

	assign vld_chain = {leaf_valid, vld_q};

	// valid bits per level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int d = 0; d < LEVELS; d++) begin
				if (en[d]) begin
					vld_q[d] <= vld_chain[d+1];
				end
			end
		end
	end

	assign leaf_take = en[LEVELS-1];
	assign root = node_q[0];
	assign root_valid = vld_q[0];

endmodule

`default_nettype wire

/* hdl/symmetric_fir_q15.sv */
// top level of the symmetric 16-tap Q1.15 FIR filter
// pipeline: window row, product cells, adder tree levels, output register, in that order;
//   each holds its item when the stage after it is full and not drained
// throughput: one sample per cycle while the output is not stalled, set by the one-per-cycle tap row and pipelined tree
// reset: history samples clear to zero, coefficients take their defaults, pipeline empties
`default_nettype none

module symmetric_fir_q15 #(
	parameter int TAPS = sfir_pkg::TAPS_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	sfir_in_if.sink                     samples,
	sfir_out_if.source                  filtered,
	input  wire logic                   cfg_we,
	input  wire sfir_pkg::pair_idx_t    cfg_index,
	input  wire sfir_pkg::coef_t        cfg_data
);

	localparam int LEVELS = $clog2(TAPS);
	localparam int AW = sfir_pkg::PROD_W + LEVELS;

	sfir_pkg::coef_t coef_q [sfir_pkg::PAIRS];
	sfir_pkg::sample_t win [TAPS];
	sfir_pkg::prod_t prod_s2 [TAPS];
	sfir_pkg::cell_ctrl_t cell_ctrl;

	logic accept;
	logic en1;
	logic en2;
	logic v1_q;
	logic v2_q;
	logic leaf_take;
	logic out_take;
	logic signed [AW-1:0] root;
	logic signed [AW-1:0] biased;
	logic root_valid;
	logic out_vld_q;
	sfir_pkg::sample_t sample_out_q;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= sfir_pkg::PAIR_RESET;
		end else if (cfg_we) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	// stage enables, output side first
	assign out_take = !out_vld_q || filtered.ready;
	assign en2 = !v2_q || leaf_take;
	assign en1 = !v1_q || en2;
	assign samples.ready = en1;
	assign accept = samples.valid && en1;

	assign cell_ctrl.shift = accept;
	assign cell_ctrl.mul = en2;

	// valid bits of the window and product stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= accept;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
		end
	end

	// row of tap cells, the first fed by the input sample, each other by its left neighbor
	genvar gk;
	for (gk = 0; gk < TAPS; gk++) begin : g_tap
		localparam int P = (gk < TAPS - 1 - gk) ? gk : TAPS - 1 - gk;
		sfir_pkg::sample_t prev;

		if (gk == 0) begin : g_head
			assign prev = samples.sample_in;
		end else begin : g_body
			assign prev = win[gk-1];
		end

		sfir_tap_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.sample_prev(prev),
			.coef       (coef_q[P]),
			.sample_q   (win[gk]),
			.prod_s2    (prod_s2[gk])
		);
	end

	sfir_add_tree #(
		.TAPS(TAPS),
		.AW  (AW)
	) u_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.leaves    (prod_s2),
		.leaf_valid(v2_q),
		.leaf_take (leaf_take),
		.take      (out_take),
		.root      (root),
		.root_valid(root_valid)
	);

	// divide by 32768 truncating toward zero: bias negative sums before the shift
	assign biased = root + (root[AW-1] ? AW'(sfir_pkg::Q15_BIAS) : AW'(0));

	// output register, low 16 bits of the quotient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_take) begin
			out_vld_q <= root_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) begin
			sample_out_q <= signed'(biased[sfir_pkg::FRAC_BITS +: sfir_pkg::SAMPLE_W]);
		end
	end

	assign filtered.valid = out_vld_q;
	assign filtered.sample_out = sample_out_q;

	// accepted sample lands in the first cell
	a_win_load: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> win[0] == $past(samples.sample_in))
		else $error("first tap cell did not take the accepted sample");

	// the history row only moves on a transfer
	a_win_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(win[0]) && $stable(win[TAPS-1]))
		else $error("history row moved without a transfer");

	// stalled products stay valid for the tree
	a_prod_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_q && !leaf_take) |=> v2_q)
		else $error("product stage lost an item while stalled");

	// a finished sum reaches the output register when it is free
	a_root_out: assert property (@(posedge clk) disable iff (!arst_n)
		(root_valid && out_take) |=> filtered.valid)
		else $error("tree result not moved to the output register");

endmodule

`default_nettype wire

/* tb/sv/sfir_checker.sv */
`timescale 1ns / 1ps
// checker for the symmetric Q1.15 FIR filter: predicts each filtered sample and compares
module sfir_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  sfir_pkg::sample_t   in_sample,
	input  logic                out_valid,
	input  logic                out_ready,
	input  sfir_pkg::sample_t   out_sample,
	input  logic                cfg_we,
	input  sfir_pkg::pair_idx_t cfg_index,
	input  sfir_pkg::coef_t     cfg_data,
	output int                  fail_count,
	output int                  pending_count,
	output int                  checked_count
);
	import sfir_pkg::*;

	localparam int NUM_TAPS = 16;
	localparam int HIST_LEN = NUM_TAPS - 1;
	localparam int Q15_ONE = 32768;

	// coefficient values after reset, one per tap pair
	localparam coef_t DEFAULT_COEFS [PAIRS] = '{
		16'sd10, -16'sd524, -16'sd898, -16'sd715,
		16'sd667, 16'sd3260, 16'sd6219, 16'sd8203
	};

	coef_t   coefs [PAIRS];
	sample_t history [HIST_LEN];
	sample_t filtered_expected_q [$];
	sample_t want;

	// full 16-tap sum of the new sample and the history, scaled back to Q1.15
	function automatic sample_t filter_output(input sample_t x);
		longint acc;
		longint quotient;
		int k;
		int pair;
		sample_t tap;
		acc = 0;
		for (k = 0; k < NUM_TAPS; k++) begin
			pair = (k < NUM_TAPS - 1 - k) ? k : NUM_TAPS - 1 - k;
			tap = (k == 0) ? x : history[k - 1];
			acc += longint'(tap) * longint'(coefs[pair]);
		end
		// division truncates toward zero, then the quotient wraps to 16 bits
		quotient = acc / Q15_ONE;
		return sample_t'(quotient[15:0]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAIRS; i++)
				coefs[i] = DEFAULT_COEFS[i];
			for (int i = 0; i < HIST_LEN; i++)
				history[i] = '0;
			filtered_expected_q.delete();
			pending_count = 0;
		end else begin
			// output transfer: compare with the oldest prediction
			if (out_valid && out_ready) begin
				if (filtered_expected_q.size() == 0) begin
					$error("sample_out: no result expected, got %0d", out_sample);
					fail_count++;
				end else begin
					want = filtered_expected_q.pop_front();
					checked_count++;
					if (out_sample !== want) begin
						$error("sample_out mismatch: expected %0d, got %0d", want, out_sample);
						fail_count++;
					end
				end
			end
			// input transfer: predict, then shift the sample into the history
			if (in_valid && in_ready) begin
				filtered_expected_q = {filtered_expected_q, filter_output(in_sample)};
				for (int i = HIST_LEN - 1; i > 0; i--)
					history[i] = history[i - 1];
				history[0] = in_sample;
			end
			// coefficient write
			if (cfg_we)
				coefs[cfg_index] = cfg_data;
			pending_count = filtered_expected_q.size();
		end
	end

endmodule

/* tb/sv/tb_symmetric_fir_q15.sv */
`timescale 1ns / 1ps
// top of the symmetric Q1.15 FIR filter testbench: stimulus, coefficient phases and verdict
module tb_symmetric_fir_q15;
	import sfir_pkg::*;

	localparam int RESET_CYCLES = 10;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 300000;
	localparam int ITEMS_PER_PHASE = 330;
	localparam int NUM_DIRECTED = 21;

	typedef enum int {
		COEF_MAX,
		COEF_MIN,
		COEF_RANDOM,
		COEF_ALTERNATE
	} coef_mode_t;

	// impulse through all taps, then the extremes and the values near zero
	localparam sample_t DIRECTED [NUM_DIRECTED] = '{
		16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
		16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
		16'sh0000, 16'sh0000, 16'sh8000, 16'shffff, 16'sh0001, 16'sh7fff, 16'sh8000
	};

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	pair_idx_t cfg_index;
	coef_t     cfg_data;

	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int samples_sent = 0;
	int settings_used = 1;
	int fail_count;
	int pending_count;
	int checked_count;

	sfir_in_if  in_ch ();
	sfir_out_if out_ch ();

	symmetric_fir_q15 DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (in_ch),
		.filtered  (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sfir_checker fir_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_ch.valid),
		.in_ready      (in_ch.ready),
		.in_sample     (in_ch.sample_in),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.out_sample    (out_ch.sample_out),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	// 12 ns clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	// output side stalls at the rate of the current phase
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// mostly uniform values, with full scale and values near zero weighted up
	function automatic sample_t pick_sample();
		case ($urandom_range(3))
			0: begin
				case ($urandom_range(3))
					0: return 16'sh7fff;
					1: return 16'sh8000;
					2: return 16'sh8001;
					default: return 16'shffff;
				endcase
			end
			1: return sample_t'(int'($urandom_range(64)) - 32);
			default: return sample_t'($urandom);
		endcase
	endfunction

	// one input transfer, with random idle cycles ahead of it; called at a falling edge
	task automatic drive_sample(input sample_t s);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			in_ch.sample_in <= sample_t'($urandom);
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample_in <= s;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		samples_sent++;
	endtask

	// random samples, partly in constant runs so long sums build up and can wrap
	task automatic run_random(input int count);
		sample_t s;
		int run_left;
		run_left = 0;
		s = '0;
		repeat (count) begin
			if (run_left == 0) begin
				s = pick_sample();
				run_left = ($urandom_range(3) == 0) ? $urandom_range(24, 1) : 1;
			end
			run_left--;
			drive_sample(s);
		end
	endtask

	// stop sending and wait until every filtered sample has come back
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
	endtask

	// write all eight tap pairs while the filter is idle
	task automatic load_coefs(input coef_mode_t mode);
		int i;
		coef_t val;
		drain();
		for (i = 0; i < PAIRS; i++) begin
			case (mode)
				COEF_MAX: val = 16'sh7fff;
				COEF_MIN: val = 16'sh8000;
				COEF_ALTERNATE: val = (i % 2 == 0) ? 16'sh7fff : 16'sh8000;
				default: val = coef_t'($urandom);
			endcase
			cfg_we <= 1'b1;
			cfg_index <= pair_idx_t'(i);
			cfg_data <= val;
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// main sequence
	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.sample_in = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// start-up from the cleared history with the default coefficients
		for (int i = 0; i < NUM_DIRECTED; i++)
			drive_sample(DIRECTED[i]);

		// all coefficients at the positive extreme, no idling
		load_coefs(COEF_MAX);
		src_idle_pct = 0;
		snk_stall_pct = 0;
		run_random(ITEMS_PER_PHASE);

		// all coefficients at the negative extreme, sender mostly idle
		load_coefs(COEF_MIN);
		src_idle_pct = 80;
		snk_stall_pct = 0;
		run_random(ITEMS_PER_PHASE);

		// random coefficients, receiver mostly stalled
		load_coefs(COEF_RANDOM);
		src_idle_pct = 0;
		snk_stall_pct = 80;
		run_random(ITEMS_PER_PHASE);

		// alternating extremes, both sides pausing
		load_coefs(COEF_ALTERNATE);
		src_idle_pct = 32;
		snk_stall_pct = 32;
		run_random(ITEMS_PER_PHASE);

		// fresh random coefficients, full rate again
		load_coefs(COEF_RANDOM);
		src_idle_pct = 0;
		snk_stall_pct = 0;
		run_random(ITEMS_PER_PHASE);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("filtered %0d samples under %0d coefficient settings, %0d results checked",
			samples_sent, settings_used, checked_count);
		$display("idling covered: none, sender 80%%, receiver 80%%, both 32%%");
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
